/* hw/rtl/bsap_pkg.sv */
`timescale 1ns / 1ps

package bsap_pkg;

   localparam int NUMBER_MAX_CHARS_DEF = 20;
   localparam int PARAM_LIMIT_MAX_DEF  = 255;

   localparam logic [7:0]  MAX_PARAMS_RESET      = 8'd16;
   localparam logic [23:0] MAX_ITEM_LENGTH_RESET = 24'd1024;

   // shorter buffers hold their status until this position
   localparam logic [31:0] MIN_BUFFER_LAST = 32'd7;

   localparam logic [7:0] CHAR_STAR   = 8'h2a;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_INCOMPLETE = 3'd1;
   localparam logic [2:0] ST_NO_STAR    = 3'd2;
   localparam logic [2:0] ST_NO_DOLLAR  = 3'd3;
   localparam logic [2:0] ST_BAD_COUNT  = 3'd4;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
   localparam logic [2:0] ST_NO_CRLF    = 3'd6;
   localparam logic [2:0] ST_NONE       = 3'd7;

   localparam int REG_MAX_PARAMS      = 0;
   localparam int REG_MAX_ITEM_LENGTH = 1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic        item_valid;
      logic [7:0]  item_index;
      logic [31:0] item_offset;
      logic [23:0] item_length;
      logic        status_valid;
      logic [2:0]  status_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  max_params;
      logic [23:0] max_item_length;
   } cfg_type;

endpackage

/* hw/rtl/bsap_core.sv */
`timescale 1ns / 1ps

module bsap_core #(
   parameter int NUMBER_MAX_CHARS = bsap_pkg::NUMBER_MAX_CHARS_DEF,
   parameter int PARAM_LIMIT_MAX  = bsap_pkg::PARAM_LIMIT_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  bsap_pkg::req_type req,
   input  bsap_pkg::cfg_type cfg,
   output logic             res_valid,
   output bsap_pkg::rsp_type res
);
   import bsap_pkg::*;

   localparam int CHAR_W = $clog2(NUMBER_MAX_CHARS + 1);

   localparam logic [3:0] PH_STAR     = 4'd0;
   localparam logic [3:0] PH_COUNT    = 4'd1;
   localparam logic [3:0] PH_HDR_LF   = 4'd2;
   localparam logic [3:0] PH_DOLLAR   = 4'd3;
   localparam logic [3:0] PH_LEN      = 4'd4;
   localparam logic [3:0] PH_LEN_LF   = 4'd5;
   localparam logic [3:0] PH_DATA     = 4'd6;
   localparam logic [3:0] PH_DAT_CR   = 4'd7;
   localparam logic [3:0] PH_DAT_LF   = 4'd8;
   localparam logic [3:0] PH_CRLF_BAD = 4'd9;
   localparam logic [3:0] PH_DONE     = 4'd10;

   function automatic logic num_ok(input logic neg, input logic [31:0] value,
                                   input logic [31:0] limit);
      num_ok = !neg && (value != 32'd0) && (value <= limit);
   endfunction

   logic [3:0]        phase_ff, phase_in;
   logic [31:0]       pos_ff, pos_in;
   logic [31:0]       value_ff, value_in;
   logic              neg_ff, neg_in;
   logic              stop_ff, stop_in;
   logic [CHAR_W-1:0] chars_ff, chars_in;
   logic [7:0]        expected_ff, expected_in;
   logic [7:0]        counter_ff, counter_in;
   logic [23:0]       remaining_ff, remaining_in;
   logic [31:0]       start_ff, start_in;
   logic [2:0]        held_ff, held_in;
   logic              sent_ff, sent_in;

   logic [7:0]  c;
   logic        eob;
   logic        is_digit, is_sign, take;
   logic [35:0] mac;
   logic [31:0] sat_value;
   logic [31:0] count_limit, len_limit;
   logic [7:0]  cap_params;
   logic [31:0] pos_inc;
   logic [7:0]  counter_inc;
   logic        item, sv;
   logic [2:0]  code;

   always_comb begin
      c        = req.byte_value;
      eob      = req.end_of_buffer;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      take     = (chars_ff < CHAR_W'(NUMBER_MAX_CHARS)) && (is_digit || is_sign);
      // times ten plus digit, saturate at all ones
      mac = ({4'd0, value_ff} << 3) + ({4'd0, value_ff} << 1)
          + {32'd0, is_digit ? (c[3:0] - CHAR_ZERO[3:0]) : 4'd0};
      sat_value   = (|mac[35:32]) ? 32'hffff_ffff : mac[31:0];
      cap_params  = (cfg.max_params < 8'(PARAM_LIMIT_MAX)) ? cfg.max_params
                                                           : 8'(PARAM_LIMIT_MAX);
      count_limit = {24'd0, cap_params};
      len_limit   = {8'd0, cfg.max_item_length};
      pos_inc     = (pos_ff == 32'hffff_ffff) ? pos_ff : pos_ff + 32'd1;
      counter_inc = counter_ff + 8'd1;

      phase_in     = phase_ff;
      pos_in       = pos_inc;
      value_in     = value_ff;
      neg_in       = neg_ff;
      stop_in      = stop_ff;
      chars_in     = chars_ff;
      expected_in  = expected_ff;
      counter_in   = counter_ff;
      remaining_in = remaining_ff;
      start_in     = start_ff;
      held_in      = held_ff;
      sent_in      = sent_ff;
      item         = 1'b0;
      sv           = 1'b0;
      code         = ST_OK;

      unique case (phase_ff)
         PH_STAR: begin
            if (c == CHAR_STAR) begin
               value_in = 32'd0;
               neg_in   = 1'b0;
               stop_in  = 1'b0;
               chars_in = '0;
               phase_in = PH_COUNT;
            end else begin
               held_in  = ST_NO_STAR;
               phase_in = PH_DONE;
            end
         end
         PH_COUNT, PH_LEN: begin
            if (take) begin
               if (!stop_ff) begin
                  if (is_digit) value_in = sat_value;
                  else if (chars_ff == '0) neg_in = (c == CHAR_MINUS);
                  else stop_in = 1'b1;
               end
               chars_in = chars_ff + CHAR_W'(1);
            end else if (phase_ff == PH_COUNT) begin
               if (!num_ok(neg_ff, value_ff, count_limit)) begin
                  held_in  = ST_BAD_COUNT;
                  phase_in = PH_DONE;
               end else begin
                  expected_in = value_ff[7:0];
                  phase_in    = (c == CHAR_CR) ? PH_HDR_LF : PH_CRLF_BAD;
               end
            end else begin
               if (!num_ok(neg_ff, value_ff, len_limit)) begin
                  held_in  = ST_BAD_LENGTH;
                  phase_in = PH_DONE;
               end else begin
                  remaining_in = value_ff[23:0];
                  phase_in     = (c == CHAR_CR) ? PH_LEN_LF : PH_CRLF_BAD;
               end
            end
         end
         PH_HDR_LF: begin
            if (c == CHAR_LF) begin
               phase_in = PH_DOLLAR;
            end else begin
               held_in  = ST_NO_CRLF;
               phase_in = PH_DONE;
            end
         end
         PH_DOLLAR: begin
            if (c == CHAR_DOLLAR) begin
               value_in = 32'd0;
               neg_in   = 1'b0;
               stop_in  = 1'b0;
               chars_in = '0;
               phase_in = PH_LEN;
            end else begin
               held_in  = ST_NO_DOLLAR;
               phase_in = PH_DONE;
            end
         end
         PH_LEN_LF: begin
            if (c == CHAR_LF) begin
               start_in = pos_inc;
               phase_in = PH_DATA;
            end else begin
               held_in  = ST_NO_CRLF;
               phase_in = PH_DONE;
            end
         end
         PH_DATA: begin
            if (remaining_ff != 24'd0) remaining_in = remaining_ff - 24'd1;
            if (remaining_ff <= 24'd1) phase_in = PH_DAT_CR;
         end
         PH_DAT_CR: begin
            phase_in = (c == CHAR_CR) ? PH_DAT_LF : PH_CRLF_BAD;
         end
         PH_DAT_LF: begin
            if (c != CHAR_LF) begin
               held_in  = ST_NO_CRLF;
               phase_in = PH_DONE;
            end else begin
               item       = 1'b1;
               counter_in = counter_inc;
               if (counter_inc == expected_ff) begin
                  held_in  = ST_OK;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DOLLAR;
               end
            end
         end
         PH_CRLF_BAD: begin
            held_in  = ST_NO_CRLF;
            phase_in = PH_DONE;
         end
         default: ;
      endcase

      // buffer ends inside a number: check it as it stands
      if (eob && (held_in == ST_NONE) && (chars_in != '0)) begin
         if (phase_in == PH_COUNT && !num_ok(neg_in, value_in, count_limit)) begin
            held_in  = ST_BAD_COUNT;
            phase_in = PH_DONE;
         end else if (phase_in == PH_LEN && !num_ok(neg_in, value_in, len_limit)) begin
            held_in  = ST_BAD_LENGTH;
            phase_in = PH_DONE;
         end
      end

      if (!sent_ff) begin
         if (held_in != ST_NONE && pos_ff >= MIN_BUFFER_LAST) begin
            sv   = 1'b1;
            code = held_in;
         end else if (eob) begin
            sv   = 1'b1;
            code = ST_INCOMPLETE;
         end
         if (sv) sent_in = 1'b1;
      end

      // rearm for the next buffer
      if (eob) begin
         phase_in     = PH_STAR;
         pos_in       = 32'd0;
         value_in     = 32'd0;
         neg_in       = 1'b0;
         stop_in      = 1'b0;
         chars_in     = '0;
         expected_in  = 8'd0;
         counter_in   = 8'd0;
         remaining_in = 24'd0;
         start_in     = 32'd0;
         held_in      = ST_NONE;
         sent_in      = 1'b0;
      end

      res = '0;
      if (item) begin
         res.item_valid  = 1'b1;
         res.item_index  = counter_ff;
         res.item_offset = start_ff;
         res.item_length = value_ff[23:0];
      end
      if (sv) begin
         res.status_valid = 1'b1;
         res.status_code  = code;
      end
      res_valid = accept && (item || sv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STAR;
         pos_ff       <= 32'd0;
         value_ff     <= 32'd0;
         neg_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         chars_ff     <= '0;
         expected_ff  <= 8'd0;
         counter_ff   <= 8'd0;
         remaining_ff <= 24'd0;
         start_ff     <= 32'd0;
         held_ff      <= ST_NONE;
         sent_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         value_ff     <= value_in;
         neg_ff       <= neg_in;
         stop_ff      <= stop_in;
         chars_ff     <= chars_in;
         expected_ff  <= expected_in;
         counter_ff   <= counter_in;
         remaining_ff <= remaining_in;
         start_ff     <= start_in;
         held_ff      <= held_in;
         sent_ff      <= sent_in;
      end
   end

endmodule

/* hw/rtl/bulk_string_array_parser.sv */
`timescale 1ns / 1ps

// Parser for a request buffer holding "*count CRLF" and count items of
// "$length CRLF data CRLF", fed one byte per transfer on the req_ channel
// (end_of_buffer marks the last byte and rearms the parser).
// Each finished item yields an rsp_ transfer with its index, data offset and
// length; the final status comes once per buffer, together with an item if
// both fall on the same byte. Item reports hold only when the status is ok.
// Bytes without a report produce no rsp_ transfer.
// A report is registered onto rsp_ (via the skid register if rsp_ stalls).
// Throughput: one byte per cycle while req_stall is low; the per-byte state
// update and the times-ten step of number parsing sit in a single register
// stage. A stalled rsp_ holds its output register; one more report goes into
// a skid register, after which req_stall rises until the output drains.
// Reset (synchronous) returns the parser to expect '*' and loads the limit
// registers with their defaults (16 params, 1024 byte items).
// Limit registers: max_params at address 0, max_item_length at address 4.
module bulk_string_array_parser #(
   parameter int NUMBER_MAX_CHARS = bsap_pkg::NUMBER_MAX_CHARS_DEF,
   parameter int PARAM_LIMIT_MAX  = bsap_pkg::PARAM_LIMIT_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsap_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsap_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bsap_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    res_valid;
   rsp_type res;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         if (paddr[2] == 1'(REG_MAX_ITEM_LENGTH)) cfg_in.max_item_length = pwdata[23:0];
         else cfg_in.max_params = pwdata[7:0];
      end
      if (paddr[2] == 1'(REG_MAX_ITEM_LENGTH)) prdata = {8'd0, cfg_ff.max_item_length};
      else prdata = {24'd0, cfg_ff.max_params};
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   bsap_core #(
      .NUMBER_MAX_CHARS(NUMBER_MAX_CHARS),
      .PARAM_LIMIT_MAX (PARAM_LIMIT_MAX)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cfg      (cfg_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_stall) begin
         // hold the output, park a new report in the skid register
         if (res_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = res_valid;
         out_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_params      <= MAX_PARAMS_RESET;
         cfg_ff.max_item_length <= MAX_ITEM_LENGTH_RESET;
         out_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
